/* sv/lr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the line rasteriser.
package lr_pkg;

	localparam int COORD_W        = 6;
	localparam int REG_W          = 7;
	localparam int ERR_W          = 10;
	localparam int SCREEN_MAX_DEF = 64;
	localparam int JOB_DEPTH_DEF  = 2;
	localparam int APB_DW         = 32;
	localparam int APB_AW         = 3;

	// register index codes, taken from paddr[2]
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} line_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic               visible;
		logic               last;
	} pixel_out_t;

	// one classified line: major axis runs a0..a1 upward, minor starts at b0
	typedef struct packed {
		logic [COORD_W-1:0] a0;
		logic [COORD_W-1:0] b0;
		logic [COORD_W-1:0] a1;
		logic [COORD_W-1:0] da;
		logic [COORD_W-1:0] db;
		logic               minor_neg;
		logic               x_major;
	} job_t;

	typedef struct packed {
		logic [REG_W-1:0] screen_width;
		logic [REG_W-1:0] screen_height;
	} cfg_t;

endpackage

/* sv/lr_front.sv */
`timescale 1ns / 1ps
// Front end: accepts a segment, picks the major axis and orders the endpoints.
module lr_front (
	input  logic              push,
	output logic              full,
	input  lr_pkg::line_in_t  in_item,
	output logic              job_push,
	input  logic              job_full,
	output lr_pkg::job_t      job
);

	logic signed [lr_pkg::COORD_W:0] dx, dy;
	logic        [lr_pkg::COORD_W:0] adx, ady;
	logic                            shallow, swap;
	logic        [lr_pkg::COORD_W-1:0] b1;

	always_comb begin
		dx  = $signed({1'b0, in_item.end_x}) - $signed({1'b0, in_item.start_x});
		dy  = $signed({1'b0, in_item.end_y}) - $signed({1'b0, in_item.start_y});
		adx = dx[lr_pkg::COORD_W] ? $unsigned(-dx) : $unsigned(dx);
		ady = dy[lr_pkg::COORD_W] ? $unsigned(-dy) : $unsigned(dy);
		shallow = ady < adx;

		if (shallow) begin
			swap   = in_item.start_x > in_item.end_x;
			job.a0 = swap ? in_item.end_x   : in_item.start_x;
			job.b0 = swap ? in_item.end_y   : in_item.start_y;
			job.a1 = swap ? in_item.start_x : in_item.end_x;
			b1     = swap ? in_item.start_y : in_item.end_y;
		end else begin
			// equal slopes fall here and step along y
			swap   = in_item.start_y > in_item.end_y;
			job.a0 = swap ? in_item.end_y   : in_item.start_y;
			job.b0 = swap ? in_item.end_x   : in_item.start_x;
			job.a1 = swap ? in_item.start_y : in_item.end_y;
			b1     = swap ? in_item.start_x : in_item.end_x;
		end

		job.x_major   = shallow;
		job.da        = job.a1 - job.a0;
		job.minor_neg = b1 < job.b0;
		job.db        = job.minor_neg ? (job.b0 - b1) : (b1 - job.b0);
	end

	assign full     = job_full;
	assign job_push = push && !job_full;

endmodule

/* sv/lr_job_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified lines between the front end and the walker.
module lr_job_fifo #(
	parameter int DEPTH = lr_pkg::JOB_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lr_pkg::job_t  wr_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output lr_pkg::job_t  rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lr_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue count beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

endmodule

/* sv/lr_walk.sv */
`timescale 1ns / 1ps
// Back end: steps a line a pixel per cycle, unless stalled, into the output reg.
module lr_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  lr_pkg::cfg_t       cfg,
	input  logic               job_valid,
	input  lr_pkg::job_t       job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output lr_pkg::pixel_out_t out_item
);

	localparam int CW = lr_pkg::COORD_W;
	localparam int EW = lr_pkg::ERR_W;

	logic                 active_q, out_valid_q;
	logic [CW-1:0]        a_q, b_q, a1_q, da_q, db_q;
	logic                 neg_q, xmaj_q;
	logic signed [EW-1:0] err_q, err_next, da2, db2;
	lr_pkg::pixel_out_t   out_q, pix;
	logic                 load, adv, err_pos;

	assign load    = !active_q && job_valid;
	assign job_pop = load;
	assign adv     = active_q && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign out_item = out_q;

	always_comb begin
		da2      = $signed(EW'({da_q, 1'b0}));
		db2      = $signed(EW'({db_q, 1'b0}));
		err_pos  = !err_q[EW-1] && (err_q != '0);
		err_next = err_q + db2 - (err_pos ? da2 : '0);

		pix.pixel_x = xmaj_q ? a_q : b_q;
		pix.pixel_y = xmaj_q ? b_q : a_q;
		pix.visible = ({1'b0, pix.pixel_x} < cfg.screen_width) &&
		              ({1'b0, pix.pixel_y} < cfg.screen_height);
		pix.last    = a_q == a1_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q    <= job.a0;
			b_q    <= job.b0;
			a1_q   <= job.a1;
			da_q   <= job.da;
			db_q   <= job.db;
			neg_q  <= job.minor_neg;
			xmaj_q <= job.x_major;
			err_q  <= $signed(EW'({job.db, 1'b0})) - $signed(EW'(job.da));
		end else if (adv) begin
			a_q   <= a_q + 1'b1;
			err_q <= err_next;
			if (err_pos) begin
				b_q <= neg_q ? b_q - 1'b1 : b_q + 1'b1;
			end
		end
		if (adv) begin
			out_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
			end else if (adv && pix.last) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pix.last |=> !active_q)
		else $error("walker kept running past the last pixel");

	a_major_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> a_q <= a1_q)
		else $error("major coordinate overran the end point");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("waiting pixel overwritten");

endmodule

/* sv/line_rasterizer_core.sv */
`timescale 1ns / 1ps
// Top level of the line rasteriser: config registers, front end, job queue, walker.
//
// Segments go in on a queue-style port: in_item is taken when push is high and full
// is low. Pixels come out on a queue-style port: out_item holds the oldest pixel
// while empty is low and is taken when pop is high. Each line gives one beat per
// pixel, stepping along its major axis, with last set on the final beat.
// The front end classifies a segment combinationally into the job queue
// (JOB_DEPTH entries), so full only rises while the queue is full.
// The walker loads a line from the queue only once it has finished the previous one,
// then produces one pixel a cycle into a single output register while pop keeps it
// drained; a 64-pixel line is the longest. The first pixel of an idle block passes
// through the job queue, the walker's line registers and the output register.
// When pop is held low the walker stops with the output register full, and the
// queue then fills and raises full; nothing is dropped.
// screen_width and screen_height sit on the APB port at 0x0 and 0x4, bits 6:0;
// a pixel is visible when it lies below both.
// Reset empties the queue and output register and sets both sizes to SCREEN_MAX.
module line_rasterizer_core #(
	parameter int SCREEN_MAX = lr_pkg::SCREEN_MAX_DEF,
	parameter int JOB_DEPTH  = lr_pkg::JOB_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  lr_pkg::line_in_t            in_item,
	output logic                        empty,
	input  logic                        pop,
	output lr_pkg::pixel_out_t          out_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lr_pkg::APB_AW-1:0]   paddr,
	input  logic [lr_pkg::APB_DW-1:0]   pwdata,
	output logic [lr_pkg::APB_DW-1:0]   prdata,
	output logic                        pready
);

	lr_pkg::cfg_t cfg_q;
	lr_pkg::job_t job_in, job_out;
	logic         job_push, job_full, job_empty, job_pop;
	logic         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= lr_pkg::REG_W'(SCREEN_MAX);
			cfg_q.screen_height <= lr_pkg::REG_W'(SCREEN_MAX);
		end else if (wr_en) begin
			if (paddr[2] == lr_pkg::REG_SCREEN_WIDTH) begin
				cfg_q.screen_width <= pwdata[lr_pkg::REG_W-1:0];
			end else begin
				cfg_q.screen_height <= pwdata[lr_pkg::REG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == lr_pkg::REG_SCREEN_HEIGHT) ?
		lr_pkg::APB_DW'(cfg_q.screen_height) : lr_pkg::APB_DW'(cfg_q.screen_width);

	lr_front u_front (
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_in)
	);

	lr_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.empty   (job_empty),
		.rd_data (job_out)
	);

	lr_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
